FILE: rtl/periodic_and_timeout_timer_bank_core_assert.svh
// assertion macros for the timer bank
`ifndef PERIODIC_AND_TIMEOUT_TIMER_BANK_CORE_ASSERT_SVH
`define PERIODIC_AND_TIMEOUT_TIMER_BANK_CORE_ASSERT_SVH

// same-cycle implication
`define TBK_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TBK_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tbk_pkg.sv
// shared types and constants of the timer bank
`timescale 1ns / 1ps

package tbk_pkg;

  localparam int PER_CH   = 8;
  localparam int TOUT_CH  = 8;
  localparam int CNT_W    = 16;
  localparam int CH_W     = 3;
  localparam int INUSE_W  = 4;
  localparam int ACT_W    = 3;
  localparam int WALK_N   = PER_CH + TOUT_CH;
  localparam int WALK_W   = $clog2(WALK_N);
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [INUSE_W-1:0] INUSE_RESET = INUSE_W'(8);

  // register indexes
  localparam logic REG_PERIODIC_IN_USE = 1'b0;
  localparam logic REG_TIMEOUTS_IN_USE = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK        = 3'd0,
    ACT_START_PER   = 3'd1,
    ACT_QUERY_PER   = 3'd2,
    ACT_CLEAR_FIRED = 3'd3,
    ACT_STOP_PER    = 3'd4,
    ACT_START_TOUT  = 3'd5,
    ACT_QUERY_TOUT  = 3'd6,
    ACT_STOP_TOUT   = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic cmd_exec;
    logic walk_step;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic walk_last;
    logic slot_free;
  } ctrl_stat_t;

endpackage

FILE: rtl/tbk_if.sv
// command and response channel interfaces of the timer bank
`timescale 1ns / 1ps

interface tbk_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [tbk_pkg::ACT_W-1:0]  action;
  logic [tbk_pkg::CH_W-1:0]   channel;
  logic [tbk_pkg::CNT_W-1:0]  count_value;

  modport source (output valid, output action, output channel, output count_value,
                  input ready);
  modport sink   (input valid, input action, input channel, input count_value,
                  output ready);
endinterface

interface tbk_rsp_if;
  logic valid;
  logic ready;
  logic fired;
  logic index_ok;

  modport source (output valid, output fired, output index_ok, input ready);
  modport sink   (input valid, input fired, input index_ok, output ready);
endinterface

FILE: rtl/periodic_and_timeout_timer_bank_core.sv
// top level of the periodic and timeout timer bank
`timescale 1ns / 1ps
// Bank of 8 periodic timers and 8 one-shot timeouts.
// cmd channel (valid/ready): one word per command: action, channel, count_value.
//   tick steps every active channel in use; start/query/clear/stop address one channel.
// rsp channel (valid/ready): exactly one word per command: fired, index_ok.
// apb port: register 0 periodic_in_use at 0x0, register 1 timeouts_in_use at 0x4,
//   4 bits each, reset 8; write them only while the bank is idle.
// a channel command is executed on acceptance; its response word is loaded into the
//   output register from the done state once that register is free; a tick first
//   walks the 16 channel entries one per cycle through a single read-modify-write port.
// only one command is in flight: the next word is taken once its response is loaded.
// a finished response sits in the output register, so a stalled receiver does
//   not stop the next command word being taken and processed; only the
//   following response waits for the register to drain.
// reset clears all active, fired and expired flags, empties the output register
//   and restores both in-use registers to 8.

`include "periodic_and_timeout_timer_bank_core_assert.svh"

module periodic_and_timeout_timer_bank_core (
  input  logic                          clk,
  input  logic                          rst,
  tbk_cmd_if.sink                       cmd,
  tbk_rsp_if.source                     rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tbk_pkg::ADDR_W-1:0]    paddr,
  input  logic [tbk_pkg::DATA_W-1:0]    pwdata,
  output logic [tbk_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  // configuration registers
  logic [tbk_pkg::INUSE_W-1:0] periodic_in_use;
  logic [tbk_pkg::INUSE_W-1:0] timeouts_in_use;
  logic                        cfg_wr;

  tbk_pkg::ctrl_cmd_t  ctl_cmd;
  tbk_pkg::ctrl_stat_t ctl_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      periodic_in_use <= tbk_pkg::INUSE_RESET;
      timeouts_in_use <= tbk_pkg::INUSE_RESET;
    end else if (cfg_wr) begin
      // register index is the word address
      if (paddr[2] == tbk_pkg::REG_PERIODIC_IN_USE) begin
        periodic_in_use <= pwdata[tbk_pkg::INUSE_W-1:0];
      end else begin
        timeouts_in_use <= pwdata[tbk_pkg::INUSE_W-1:0];
      end
    end
  end

  // read back, zero extended
  always_comb begin
    if (paddr[2] == tbk_pkg::REG_TIMEOUTS_IN_USE) begin
      prdata = tbk_pkg::DATA_W'(timeouts_in_use);
    end else begin
      prdata = tbk_pkg::DATA_W'(periodic_in_use);
    end
  end

  // sequencing of accept, tick walk and response load
  tbk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .stat     (ctl_stat),
    .cmd      (ctl_cmd)
  );

  // channel state and output register
  tbk_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (ctl_cmd),
    .stat            (ctl_stat),
    .action          (cmd.action),
    .channel         (cmd.channel),
    .count_value     (cmd.count_value),
    .periodic_in_use (periodic_in_use),
    .timeouts_in_use (timeouts_in_use),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_fired       (rsp.fired),
    .out_index_ok    (rsp.index_ok)
  );

  // a response is only loaded into a free or draining output register
  `TBK_ASSERT_NOW(a_load_slot_free, clk, rst, ctl_cmd.out_load, !rsp.valid || rsp.ready, "response loaded over a held word")
  // a loaded response is offered next cycle
  `TBK_ASSERT_NEXT(a_load_shows, clk, rst, ctl_cmd.out_load, rsp.valid, "loaded response not offered")
  // an accepted tick blocks intake while it walks
  `TBK_ASSERT_NEXT(a_tick_blocks, clk, rst, cmd.valid && cmd.ready && cmd.action == tbk_pkg::ACT_TICK, !cmd.ready, "command taken during tick walk")
  // the walk stops after its last entry
  `TBK_ASSERT_NEXT(a_walk_ends, clk, rst, ctl_cmd.walk_step && ctl_stat.walk_last, !ctl_cmd.walk_step, "walk ran past last entry")

endmodule

FILE: rtl/tbk_ctrl.sv
// controller state machine of the timer bank
`timescale 1ns / 1ps

module tbk_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tbk_pkg::ctrl_stat_t stat,
  output tbk_pkg::ctrl_cmd_t  cmd
);

  tbk_pkg::state_t state;
  tbk_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tbk_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tbk_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = stat.is_tick ? tbk_pkg::ST_WALK : tbk_pkg::ST_DONE;
        end
      end
      tbk_pkg::ST_WALK: begin
        if (stat.walk_last) begin
          state_next = tbk_pkg::ST_DONE;
        end
      end
      tbk_pkg::ST_DONE: begin
        if (stat.slot_free) begin
          state_next = tbk_pkg::ST_IDLE;
        end
      end
      default: state_next = tbk_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.cmd_exec  = 1'b0;
    cmd.walk_step = 1'b0;
    cmd.out_load  = 1'b0;
    case (state)
      tbk_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.cmd_exec = in_valid;
      end
      tbk_pkg::ST_WALK: cmd.walk_step = 1'b1;
      tbk_pkg::ST_DONE: cmd.out_load  = stat.slot_free;
      default: in_ready = 1'b0;
    endcase
  end

endmodule

FILE: rtl/tbk_dpath.sv
// channel state, tick walk and result register of the timer bank
`timescale 1ns / 1ps

module tbk_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  tbk_pkg::ctrl_cmd_t            cmd,
  output tbk_pkg::ctrl_stat_t           stat,
  input  logic [tbk_pkg::ACT_W-1:0]     action,
  input  logic [tbk_pkg::CH_W-1:0]      channel,
  input  logic [tbk_pkg::CNT_W-1:0]     count_value,
  input  logic [tbk_pkg::INUSE_W-1:0]   periodic_in_use,
  input  logic [tbk_pkg::INUSE_W-1:0]   timeouts_in_use,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_fired,
  output logic                          out_index_ok
);

  localparam logic [tbk_pkg::INUSE_W-1:0] PER_MAX  = tbk_pkg::INUSE_W'(tbk_pkg::PER_CH);
  localparam logic [tbk_pkg::INUSE_W-1:0] TOUT_MAX = tbk_pkg::INUSE_W'(tbk_pkg::TOUT_CH);
  localparam logic [tbk_pkg::WALK_W-1:0]  WALK_PER = tbk_pkg::WALK_W'(tbk_pkg::PER_CH);
  localparam logic [tbk_pkg::WALK_W-1:0]  WALK_END = tbk_pkg::WALK_W'(tbk_pkg::WALK_N - 1);

  logic [tbk_pkg::CNT_W-1:0] per_count  [tbk_pkg::PER_CH];
  logic [tbk_pkg::CNT_W-1:0] per_reload [tbk_pkg::PER_CH];
  logic [tbk_pkg::CNT_W-1:0] tout_count [tbk_pkg::TOUT_CH];
  logic [tbk_pkg::PER_CH-1:0]  per_active;
  logic [tbk_pkg::PER_CH-1:0]  per_fired;
  logic [tbk_pkg::TOUT_CH-1:0] tout_active;
  logic [tbk_pkg::TOUT_CH-1:0] tout_zero;

  logic [tbk_pkg::WALK_W-1:0]  walk_idx;
  logic                        res_fired;
  logic                        res_ok;

  logic [tbk_pkg::INUSE_W-1:0] np;
  logic [tbk_pkg::INUSE_W-1:0] nt;
  logic                        pok;
  logic                        tok;
  logic                        walk_per;
  logic [tbk_pkg::CH_W-1:0]    wch;
  logic [tbk_pkg::CNT_W-1:0]   per_dec;
  logic [tbk_pkg::CNT_W-1:0]   tout_dec;
  logic                        per_hit;
  logic                        tout_hit;
  tbk_pkg::action_t            act;

  assign act      = tbk_pkg::action_t'(action);
  assign np       = (periodic_in_use > PER_MAX) ? PER_MAX : periodic_in_use;
  assign nt       = (timeouts_in_use > TOUT_MAX) ? TOUT_MAX : timeouts_in_use;
  assign pok      = {1'b0, channel} < np;
  assign tok      = {1'b0, channel} < nt;

  // walk: periodic entries first, then timeouts
  assign walk_per = walk_idx < WALK_PER;
  assign wch      = walk_per ? walk_idx[tbk_pkg::CH_W-1:0]
                             : tbk_pkg::CH_W'(walk_idx - WALK_PER);
  assign per_dec  = per_count[wch] - 1'b1;
  assign tout_dec = tout_count[wch] - 1'b1;
  assign per_hit  = cmd.walk_step && walk_per && ({1'b0, wch} < np) && per_active[wch];
  assign tout_hit = cmd.walk_step && !walk_per && ({1'b0, wch} < nt) && tout_active[wch]
                    && !tout_zero[wch];

  assign stat.is_tick   = act == tbk_pkg::ACT_TICK;
  assign stat.walk_last = walk_idx == WALK_END;
  assign stat.slot_free = !out_valid || out_ready;

  // flags and walk index
  always_ff @(posedge clk) begin
    if (rst) begin
      per_active  <= '0;
      per_fired   <= '0;
      tout_active <= '0;
      tout_zero   <= '0;
      walk_idx    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.cmd_exec) begin
        walk_idx <= '0;
        case (act)
          tbk_pkg::ACT_START_PER: begin
            if (pok) begin
              per_active[channel] <= 1'b1;
              per_fired[channel]  <= 1'b0;
            end
          end
          tbk_pkg::ACT_CLEAR_FIRED: begin
            if (pok) per_fired[channel] <= 1'b0;
          end
          tbk_pkg::ACT_STOP_PER: begin
            if (pok) begin
              per_active[channel] <= 1'b0;
              per_fired[channel]  <= 1'b0;
            end
          end
          tbk_pkg::ACT_START_TOUT: begin
            if (tok) begin
              tout_active[channel] <= 1'b1;
              tout_zero[channel]   <= count_value == '0;
            end
          end
          tbk_pkg::ACT_STOP_TOUT: begin
            if (tok) tout_active[channel] <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.walk_step) begin
        walk_idx <= walk_idx + 1'b1;
      end
      if (per_hit && per_dec == '0) begin
        per_fired[wch] <= 1'b1;
      end
      if (tout_hit && tout_dec == '0) begin
        tout_zero[wch] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // counters, reload values and result
  always_ff @(posedge clk) begin
    if (cmd.cmd_exec) begin
      res_fired <= ((act == tbk_pkg::ACT_QUERY_PER) && pok && per_fired[channel])
                   || ((act == tbk_pkg::ACT_QUERY_TOUT) && tok && tout_zero[channel]);
      res_ok    <= (act == tbk_pkg::ACT_TICK) ? 1'b1 : (action < tbk_pkg::ACT_START_TOUT)
                   ? pok : tok;
      case (act)
        tbk_pkg::ACT_START_PER: begin
          if (pok) begin
            per_count[channel]  <= count_value;
            per_reload[channel] <= count_value;
          end
        end
        tbk_pkg::ACT_START_TOUT: begin
          if (tok) tout_count[channel] <= count_value;
        end
        default: begin
        end
      endcase
    end
    if (per_hit) begin
      per_count[wch] <= (per_dec == '0) ? per_reload[wch] : per_dec;
    end
    if (tout_hit) begin
      tout_count[wch] <= tout_dec;
    end
    if (cmd.out_load) begin
      out_fired    <= res_fired;
      out_index_ok <= res_ok;
    end
  end

endmodule

FILE: tb/sv/periodic_and_timeout_timer_bank_core_tb.sv
// self-checking testbench of the periodic and timeout timer bank core
`timescale 1ns / 1ps

module periodic_and_timeout_timer_bank_core_tb;
  import tbk_pkg::*;

  // generous bound: ~530 words, each tick walking all 16 entries, plus both sides stalling
  localparam int CYCLE_LIMIT   = 300000;
  // a tick walks all 16 entries before its answer, so wait a little beyond that
  localparam int SETTLE_CYCLES = 24;
  localparam int REPORT_MAX    = 10;

  // one answer word as the bank should give it
  typedef struct packed {
    logic fired;
    logic index_ok;
  } answer_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  tbk_cmd_if cmd_ch ();
  tbk_rsp_if rsp_ch ();

  periodic_and_timeout_timer_bank_core DUT (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow copy of the bank, advanced once per accepted command word
  logic [CNT_W-1:0]   per_left    [PER_CH];
  logic [CNT_W-1:0]   per_period  [PER_CH];
  logic               per_running [PER_CH];
  logic               per_flag    [PER_CH];
  logic [CNT_W-1:0]   tmo_left    [TOUT_CH];
  logic               tmo_running [TOUT_CH];
  logic [INUSE_W-1:0] per_in_use;
  logic [INUSE_W-1:0] tmo_in_use;

  // answers owed by the bank, oldest first
  answer_t pending_answers [$];

  bit idle_off = 1'b0;   // set for the stretch where neither side pauses
  int cycle_count    = 0;
  int mismatch_count = 0;
  int words_sent     = 0;
  int ticks_sent     = 0;
  int answers_checked = 0;
  int fired_answers  = 0;
  int settings_used  = 0;

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // bank state straight after reset
  function automatic void reset_shadow();
    for (int i = 0; i < PER_CH; i++) begin
      per_left[i]    = '0;
      per_period[i]  = '0;
      per_running[i] = 1'b0;
      per_flag[i]    = 1'b0;
    end
    for (int i = 0; i < TOUT_CH; i++) begin
      tmo_left[i]    = CNT_W'(1);   // never started, so not expired
      tmo_running[i] = 1'b0;
    end
    per_in_use = INUSE_RESET;
    tmo_in_use = INUSE_RESET;
  endfunction

  // applies one command word to the shadow bank and returns its answer
  function automatic answer_t timer_bank_step(input action_t act,
                                              input logic [CH_W-1:0] ch,
                                              input logic [CNT_W-1:0] val);
    int      n_per;
    int      n_tmo;
    logic    per_ok;
    logic    tmo_ok;
    answer_t ans;
    // in-use registers above the channel count are clamped
    n_per  = (per_in_use < PER_CH) ? int'(per_in_use) : PER_CH;
    n_tmo  = (tmo_in_use < TOUT_CH) ? int'(tmo_in_use) : TOUT_CH;
    per_ok = int'(ch) < n_per;
    tmo_ok = int'(ch) < n_tmo;
    ans    = '0;
    case (act)
      ACT_TICK: begin
        ans.index_ok = 1'b1;
        for (int i = 0; i < n_per; i++) begin
          if (per_running[i]) begin
            // a period of zero wraps here and so lasts the full counter range
            per_left[i] = per_left[i] - 1'b1;
            if (per_left[i] == '0) begin
              per_left[i] = per_period[i];
              per_flag[i] = 1'b1;
            end
          end
        end
        for (int i = 0; i < n_tmo; i++) begin
          // timeouts stick at zero
          if (tmo_running[i] && tmo_left[i] != '0) tmo_left[i] = tmo_left[i] - 1'b1;
        end
      end
      ACT_START_PER: begin
        ans.index_ok = per_ok;
        if (per_ok) begin
          per_left[ch]    = val;
          per_period[ch]  = val;
          per_running[ch] = 1'b1;
          per_flag[ch]    = 1'b0;
        end
      end
      ACT_QUERY_PER: begin
        ans.index_ok = per_ok;
        if (per_ok) ans.fired = per_flag[ch];
      end
      ACT_CLEAR_FIRED: begin
        ans.index_ok = per_ok;
        if (per_ok) per_flag[ch] = 1'b0;
      end
      ACT_STOP_PER: begin
        ans.index_ok = per_ok;
        if (per_ok) begin
          per_running[ch] = 1'b0;
          per_flag[ch]    = 1'b0;
        end
      end
      ACT_START_TOUT: begin
        ans.index_ok = tmo_ok;
        if (tmo_ok) begin
          tmo_left[ch]    = val;
          tmo_running[ch] = 1'b1;
        end
      end
      ACT_QUERY_TOUT: begin
        ans.index_ok = tmo_ok;
        if (tmo_ok) ans.fired = (tmo_left[ch] == '0);
      end
      default: begin
        // stopping a timeout keeps its count, so its expired answer stays
        ans.index_ok = tmo_ok;
        if (tmo_ok) tmo_running[ch] = 1'b0;
      end
    endcase
    return ans;
  endfunction

  function automatic void report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                          input logic [DATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("mismatch at cycle %0d: %s expected %0h got %0h", cycle_count, what, want, got);
  endfunction

  // sends one command word, pausing at random first, and books its answer
  task automatic send_word(input action_t act, input logic [CH_W-1:0] ch,
                           input logic [CNT_W-1:0] val);
    while (!idle_off && $urandom_range(0, 99) < 37) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.action      <= act;
    cmd_ch.channel     <= ch;
    cmd_ch.count_value <= val;
    do @(posedge clk); while (!cmd_ch.ready);
    pending_answers.push_back(timer_bank_step(act, ch, val));
    words_sent++;
    if (act == ACT_TICK) ticks_sent++;
  endtask

  // called at the edge that took the last word: drop valid, let the bank drain
  task automatic wait_bank_idle();
    cmd_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write of one in-use register, then a read back of it
  task automatic apb_write(input logic reg_idx, input logic [INUSE_W-1:0] value);
    logic [DATA_W-1:0] read_back;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == REG_PERIODIC_IN_USE) per_in_use = value;
    else tmo_in_use = value;
    // back-to-back read of the same address
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    read_back = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (read_back !== DATA_W'(value))
      report_mismatch("register read back", DATA_W'(value), read_back);
  endtask

  task automatic set_in_use(input logic [INUSE_W-1:0] per_n, input logic [INUSE_W-1:0] tmo_n);
    apb_write(REG_PERIODIC_IN_USE, per_n);
    apb_write(REG_TIMEOUTS_IN_USE, tmo_n);
    settings_used++;
  endtask

  // answers straight after reset: nothing fired, nothing expired
  task automatic test_reset_answers();
    send_word(ACT_QUERY_PER, CH_W'(0), '0);
    send_word(ACT_QUERY_TOUT, CH_W'(7), '1);
    wait_bank_idle();
  endtask

  // periodic firing, and the zero period that wraps instead of firing
  task automatic test_periodic_fire();
    send_word(ACT_START_PER, CH_W'(0), CNT_W'(2));
    send_word(ACT_START_PER, CH_W'(7), '0);
    send_word(ACT_TICK, CH_W'(5), '1);
    send_word(ACT_QUERY_PER, CH_W'(0), '0);
    send_word(ACT_TICK, CH_W'(0), '0);
    send_word(ACT_QUERY_PER, CH_W'(0), '0);
    send_word(ACT_QUERY_PER, CH_W'(7), '0);
    wait_bank_idle();
  endtask

  // timeouts: zero length expires at once, counting sticks at zero
  task automatic test_timeout_expiry();
    send_word(ACT_START_TOUT, CH_W'(1), CNT_W'(1));
    send_word(ACT_START_TOUT, CH_W'(2), '0);
    send_word(ACT_START_TOUT, CH_W'(3), '1);
    send_word(ACT_QUERY_TOUT, CH_W'(2), '0);
    send_word(ACT_TICK, CH_W'(0), '0);
    send_word(ACT_QUERY_TOUT, CH_W'(1), '0);
    send_word(ACT_TICK, CH_W'(0), '0);
    send_word(ACT_QUERY_TOUT, CH_W'(1), '0);
    wait_bank_idle();
  endtask

  // clear, stop of both kinds, and a restart of a periodic channel
  task automatic test_clear_and_stop();
    send_word(ACT_CLEAR_FIRED, CH_W'(0), '0);
    send_word(ACT_QUERY_PER, CH_W'(0), '0);
    send_word(ACT_STOP_PER, CH_W'(7), '0);
    send_word(ACT_STOP_TOUT, CH_W'(2), '0);
    send_word(ACT_QUERY_TOUT, CH_W'(2), '0);
    send_word(ACT_START_PER, CH_W'(0), '1);
    wait_bank_idle();
  endtask

  // channels beyond a reduced count are refused; a count above
  // the channel total is clamped
  task automatic test_reduced_counts();
    set_in_use(INUSE_W'(2), '1);
    send_word(ACT_START_PER, CH_W'(5), CNT_W'(1));
    send_word(ACT_QUERY_PER, CH_W'(2), '0);
    send_word(ACT_START_TOUT, CH_W'(7), CNT_W'(1));
    send_word(ACT_TICK, CH_W'(0), '0);
    send_word(ACT_QUERY_TOUT, CH_W'(7), '0);
    wait_bank_idle();
    set_in_use(INUSE_RESET, INUSE_RESET);
    send_word(ACT_QUERY_PER, CH_W'(5), '0);
    wait_bank_idle();
  endtask

  // random mix weighted towards starts, ticks and queries so channels fire
  task automatic test_random_mix(input int n_words, input bit steady);
    int               pick;
    action_t          act;
    logic [CNT_W-1:0] val;
    idle_off = steady;
    for (int k = 0; k < n_words; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 36) act = ACT_TICK;
      else if (pick < 48) act = ACT_START_PER;
      else if (pick < 62) act = ACT_QUERY_PER;
      else if (pick < 68) act = ACT_CLEAR_FIRED;
      else if (pick < 72) act = ACT_STOP_PER;
      else if (pick < 82) act = ACT_START_TOUT;
      else if (pick < 95) act = ACT_QUERY_TOUT;
      else act = ACT_STOP_TOUT;
      // mostly short periods so firing is common, sometimes any length
      if ($urandom_range(0, 3) == 0) val = CNT_W'($urandom);
      else val = CNT_W'($urandom_range(0, 6));
      send_word(act, CH_W'($urandom_range(0, 7)), val);
    end
    wait_bank_idle();
    idle_off = 1'b0;
  endtask

  // receiver side: random back-pressure on the answer channel
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= idle_off || ($urandom_range(0, 99) >= 37);
    end
  end

  // every taken answer word against the oldest booked answer
  always @(posedge clk) begin : check_answers
    answer_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("answer with no command outstanding", '0,
                        DATA_W'({rsp_ch.fired, rsp_ch.index_ok}));
      end else begin
        want = pending_answers.pop_front();
        answers_checked++;
        if (want.fired) fired_answers++;
        if (rsp_ch.fired !== want.fired)
          report_mismatch("fired", DATA_W'(want.fired), DATA_W'(rsp_ch.fired));
        if (rsp_ch.index_ok !== want.index_ok)
          report_mismatch("index_ok", DATA_W'(want.index_ok), DATA_W'(rsp_ch.index_ok));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d answers outstanding", cycle_count,
               pending_answers.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.action      <= ACT_TICK;
    cmd_ch.channel     <= '0;
    cmd_ch.count_value <= '0;
    reset_shadow();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_answers();
    test_periodic_fire();
    test_timeout_expiry();
    test_clear_and_stop();
    test_reduced_counts();

    // random phases over several in-use settings, state carried across them
    set_in_use(INUSE_RESET, INUSE_RESET);
    test_random_mix(120, 1'b0);
    set_in_use('0, '1);
    test_random_mix(60, 1'b0);
    set_in_use(INUSE_W'(5), INUSE_W'(3));
    test_random_mix(100, 1'b1);
    set_in_use('1, '0);
    test_random_mix(60, 1'b0);
    set_in_use(INUSE_RESET, INUSE_RESET);
    test_random_mix(160, 1'b0);

    $display("sent %0d command words (%0d ticks) across %0d in-use settings",
             words_sent, ticks_sent, settings_used);
    $display("checked %0d answer words, %0d of them with fired set",
             answers_checked, fired_answers);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
